### rtl/core/ivwm_pkg.sv
// ----------------------------------------------------------------------------
// ivwm_pkg
// Types, microcode format and control store of the inverse-variance
// weighted mean block.
// ----------------------------------------------------------------------------
package ivwm_pkg;

    // one input beat: measurement in signed Q16.16, sigma in unsigned Q8.8
    typedef struct packed {
        logic signed [31:0] measured_value;
        logic        [15:0] uncertainty;
        logic               is_last;
    } t_in;

    // one result beat
    typedef struct packed {
        logic signed [31:0] weighted_mean;
        logic               error_flag;
    } t_out;

    localparam int NUM_W = 64;   // weighted sum, signed Q32.32
    localparam int DEN_W = 48;   // weight sum, unsigned Q32.16
    localparam int QUO_W = 64;   // divider dividend / quotient register
    localparam int CNT_W = 6;    // divider iteration counter
    localparam int STEP_W = 4;   // microcode step counter

    typedef logic [STEP_W-1:0] t_step;
    typedef logic [CNT_W-1:0]  t_cnt;

    // 2^32 as a 33-bit dividend, placed at the top of the quotient register
    localparam logic [QUO_W-1:0] W_DIVIDEND = {1'b1, {(QUO_W-1){1'b0}}};
    localparam t_cnt W_DIV_LAST = t_cnt'(32);   // 33 quotient bits
    localparam t_cnt M_DIV_LAST = t_cnt'(63);   // 64 quotient bits

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_ACCEPT = 4'd1,   // take an input beat
        OP_WLOAD  = 4'd2,   // flag zero sigma, load 2^32 / sigma^2
        OP_DIV    = 4'd3,   // one restoring divider step
        OP_WSAT   = 4'd4,   // saturate weight
        OP_MUL    = 4'd5,   // x * w
        OP_ACC    = 4'd6,   // update both sums
        OP_MLOAD  = 4'd7,   // load |num| / den
        OP_ERRRES = 4'd8,   // preset error result
        OP_MSAT   = 4'd9,   // sign and saturate mean
        OP_EMIT   = 4'd10   // load output register, clear sums
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER   = 3'd0,
        C_ALWAYS  = 3'd1,
        C_NOACC   = 3'd2,   // no input beat offered
        C_SZERO   = 3'd3,   // sigma is zero
        C_CNTNZ   = 3'd4,   // divider still iterating
        C_NOTLAST = 3'd5,
        C_BAD     = 3'd6,   // error seen or empty denominator
        C_OBUSY   = 3'd7    // output register still held
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step S_WAIT = t_step'(0);
    localparam t_step S_CHKS = t_step'(1);
    localparam t_step S_WDIV = t_step'(2);
    localparam t_step S_WSAT = t_step'(3);
    localparam t_step S_MUL  = t_step'(4);
    localparam t_step S_ACC  = t_step'(5);
    localparam t_step S_LAST = t_step'(6);
    localparam t_step S_CHKE = t_step'(7);
    localparam t_step S_MDIV = t_step'(8);
    localparam t_step S_MSAT = t_step'(9);
    localparam t_step S_EMIT = t_step'(10);
    localparam t_step S_BACK = t_step'(11);

    // control store: jump to target when the condition holds, else fall through
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        case (step)
            S_WAIT:  w = '{OP_ACCEPT, C_NOACC,   S_WAIT};
            S_CHKS:  w = '{OP_WLOAD,  C_SZERO,   S_LAST};
            S_WDIV:  w = '{OP_DIV,    C_CNTNZ,   S_WDIV};
            S_WSAT:  w = '{OP_WSAT,   C_NEVER,   S_WAIT};
            S_MUL:   w = '{OP_MUL,    C_NEVER,   S_WAIT};
            S_ACC:   w = '{OP_ACC,    C_NEVER,   S_WAIT};
            S_LAST:  w = '{OP_MLOAD,  C_NOTLAST, S_WAIT};
            S_CHKE:  w = '{OP_ERRRES, C_BAD,     S_EMIT};
            S_MDIV:  w = '{OP_DIV,    C_CNTNZ,   S_MDIV};
            S_MSAT:  w = '{OP_MSAT,   C_NEVER,   S_WAIT};
            S_EMIT:  w = '{OP_EMIT,   C_OBUSY,   S_EMIT};
            S_BACK:  w = '{OP_NOP,    C_ALWAYS,  S_WAIT};
            default: w = '{OP_NOP,    C_ALWAYS,  S_WAIT};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/inverse_variance_weighted_mean.sv
// ----------------------------------------------------------------------------
// inverse_variance_weighted_mean
// Streams (x, sigma) pairs, accumulates x/sigma^2 and 1/sigma^2, and on the
// last pair of a set emits the weighted mean in Q16.16 with an error flag.
// ----------------------------------------------------------------------------
// One input beat is taken at a time; the next pair is not accepted until the
// current one is through. A pair with nonzero sigma runs through the 33 steps
// of the shared radix-2 restoring divider forming 2^32/sigma^2; a zero sigma
// skips the division. A last pair adds the 64-step division of the sums, which
// is skipped when the set is in error, and it holds further while an earlier
// result is still waiting in the output register. The result sits in that
// register, so the next pair is accepted while it waits; the sums are cleared
// when the result is loaded.

module inverse_variance_weighted_mean (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ivwm_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ivwm_pkg::t_out  o_out_data
);

    ivwm_pkg::t_uword uword;
    ivwm_pkg::t_step  r_step;
    ivwm_pkg::t_step  n_step;
    ivwm_pkg::t_cnt   r_cnt;
    logic             jump;
    logic             out_busy;

    // latched input beat
    logic signed [31:0] r_x;
    logic        [15:0] r_s;
    logic               r_last;

    // divider
    logic [ivwm_pkg::DEN_W-1:0] r_rem;
    logic [ivwm_pkg::QUO_W-1:0] r_quo;
    logic [ivwm_pkg::DEN_W-1:0] r_dvs;
    logic [ivwm_pkg::DEN_W:0]   div_sh;
    logic [ivwm_pkg::DEN_W:0]   div_diff;
    logic                       div_ge;

    // weight and product
    logic [31:0]                r_w;
    logic [ivwm_pkg::NUM_W-1:0] r_prod;
    logic [31:0]                sq;
    logic signed [64:0]         mul_full;

    // sums
    logic [ivwm_pkg::NUM_W-1:0] r_num;
    logic [ivwm_pkg::DEN_W-1:0] r_den;
    logic                       r_err;
    logic [ivwm_pkg::NUM_W-1:0] num_next;
    logic [ivwm_pkg::DEN_W:0]   den_next;
    logic                       num_ovf;
    logic [ivwm_pkg::NUM_W-1:0] num_mag;

    // result
    logic [31:0]    r_mean;
    logic           r_merr;
    logic [31:0]    mean_sat;
    logic           r_out_valid;
    ivwm_pkg::t_out r_out_data;

    assign uword    = ivwm_pkg::ucode_rom(r_step);
    assign out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        case (uword.cond)
            ivwm_pkg::C_NEVER:   jump = 1'b0;
            ivwm_pkg::C_ALWAYS:  jump = 1'b1;
            ivwm_pkg::C_NOACC:   jump = !i_in_valid;
            ivwm_pkg::C_SZERO:   jump = (r_s == '0);
            ivwm_pkg::C_CNTNZ:   jump = (r_cnt != '0);
            ivwm_pkg::C_NOTLAST: jump = !r_last;
            ivwm_pkg::C_BAD:     jump = r_err || (r_den == '0);
            ivwm_pkg::C_OBUSY:   jump = out_busy;
            default:             jump = 1'b1;
        endcase
        n_step = jump ? uword.target : r_step + ivwm_pkg::t_step'(1);
    end

    assign o_in_ready = (uword.op == ivwm_pkg::OP_ACCEPT);

    // datapath combinational pieces
    always_comb begin
        sq       = {16'd0, r_s} * {16'd0, r_s};
        div_sh   = {r_rem, r_quo[ivwm_pkg::QUO_W-1]};
        div_diff = div_sh - {1'b0, r_dvs};
        div_ge   = (div_sh >= {1'b0, r_dvs});
        mul_full = {{33{r_x[31]}}, r_x} * {33'd0, r_w};
        num_next = r_num + r_prod;
        num_ovf  = ((r_num[63] ^ num_next[63]) & (r_prod[63] ^ num_next[63]));
        den_next = {1'b0, r_den} + {17'd0, r_w};
        num_mag  = r_num[63] ? (64'd0 - r_num) : r_num;
        // quotient magnitude is in r_quo, sign is the sum's sign
        if (r_num[63]) begin
            if (r_quo > {32'd0, ivwm_pkg::NEG_LIMIT}) begin
                mean_sat = ivwm_pkg::NEG_LIMIT;
            end else begin
                mean_sat = 32'd0 - r_quo[31:0];
            end
        end else begin
            if (r_quo > {32'd0, ivwm_pkg::POS_LIMIT}) begin
                mean_sat = ivwm_pkg::POS_LIMIT;
            end else begin
                mean_sat = r_quo[31:0];
            end
        end
    end

    // control and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ivwm_pkg::S_WAIT;
            r_cnt       <= '0;
            r_num       <= '0;
            r_den       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (uword.op == ivwm_pkg::OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (uword.op)
                ivwm_pkg::OP_WLOAD: begin
                    r_cnt <= ivwm_pkg::W_DIV_LAST;
                    if (r_s == '0) begin
                        r_err <= 1'b1;
                    end
                end
                ivwm_pkg::OP_DIV: begin
                    r_cnt <= r_cnt - ivwm_pkg::t_cnt'(1);
                end
                ivwm_pkg::OP_ACC: begin
                    r_num <= num_next;
                    r_den <= den_next[ivwm_pkg::DEN_W-1:0];
                    if (num_ovf || den_next[ivwm_pkg::DEN_W]) begin
                        r_err <= 1'b1;
                    end
                end
                ivwm_pkg::OP_MLOAD: begin
                    r_cnt <= ivwm_pkg::M_DIV_LAST;
                end
                ivwm_pkg::OP_EMIT: begin
                    if (!out_busy) begin
                        r_num <= '0;
                        r_den <= '0;
                        r_err <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (uword.op)
            ivwm_pkg::OP_ACCEPT: begin
                r_x    <= i_in_data.measured_value;
                r_s    <= i_in_data.uncertainty;
                r_last <= i_in_data.is_last;
            end
            ivwm_pkg::OP_WLOAD: begin
                r_rem <= '0;
                r_quo <= ivwm_pkg::W_DIVIDEND;
                r_dvs <= {16'd0, sq};
            end
            ivwm_pkg::OP_DIV: begin
                r_rem <= div_ge ? div_diff[ivwm_pkg::DEN_W-1:0]
                                : div_sh[ivwm_pkg::DEN_W-1:0];
                r_quo <= {r_quo[ivwm_pkg::QUO_W-2:0], div_ge};
            end
            ivwm_pkg::OP_WSAT: begin
                // only sigma of one lsb gives a 33-bit quotient
                r_w <= r_quo[32] ? 32'hFFFF_FFFF : r_quo[31:0];
            end
            ivwm_pkg::OP_MUL: begin
                r_prod <= mul_full[ivwm_pkg::NUM_W-1:0];
            end
            ivwm_pkg::OP_MLOAD: begin
                r_rem <= '0;
                r_quo <= num_mag;
                r_dvs <= r_den;
            end
            ivwm_pkg::OP_ERRRES: begin
                r_mean <= '0;
                r_merr <= 1'b1;
            end
            ivwm_pkg::OP_MSAT: begin
                r_mean <= mean_sat;
                r_merr <= 1'b0;
            end
            ivwm_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    r_out_data.weighted_mean <= r_mean;
                    r_out_data.error_flag    <= r_merr;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### tb/inverse_variance_weighted_mean_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_variance_weighted_mean_tb
// Drives (x, sigma) pairs through the weighted mean block with random idling on
// both channels. A bit-level software copy of the accumulator predicts each mean
// unless a row gives its own; every output beat is checked in order against it.
// ----------------------------------------------------------------------------
module inverse_variance_weighted_mean_tb;

    typedef struct packed {
        ivwm_pkg::t_in  beat;
        logic           typed;    // expected result given in the row itself
        ivwm_pkg::t_out res;
    } t_row;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM = 1950;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{32'h0001_0000, 16'h0100, 1'b1}, 1'b1, '{32'h0001_0000, 1'b0}},
        '{'{32'h7FFF_FFFF, 16'hFFFF, 1'b1}, 1'b1, '{32'h7FFF_FFFF, 1'b0}},
        '{'{32'h8000_0000, 16'h0001, 1'b1}, 1'b1, '{32'h8000_0000, 1'b0}},
        '{'{32'h7FFF_FFFF, 16'h0001, 1'b1}, 1'b1, '{32'h7FFF_FFFF, 1'b0}},
        '{'{32'h8000_0000, 16'hFFFF, 1'b1}, 1'b1, '{32'h8000_0000, 1'b0}},
        // zero sigma alone leaves the denominator empty
        '{'{32'h1234_5678, 16'h0000, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1}},
        '{'{32'h0003_0000, 16'h0100, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'hFFFF_0000, 16'h0000, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'h0002_0000, 16'h0200, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1}},
        // weighted sum runs past the negative limit
        '{'{32'h8000_0000, 16'h0001, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'h8000_0000, 16'h0001, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1}},
        // and past the positive limit
        '{'{32'h7FFF_FFFF, 16'h0001, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'h7FFF_FFFF, 16'h0001, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1}},
        '{'{32'hFFFF_0000, 16'h0080, 1'b1}, 1'b1, '{32'hFFFF_0000, 1'b0}},
        '{'{32'hAAAA_AAAA, 16'h5555, 1'b1}, 1'b1, '{32'hAAAA_AAAA, 1'b0}},
        '{'{32'h5555_5555, 16'hAAAA, 1'b1}, 1'b1, '{32'h5555_5555, 1'b0}},
        '{'{32'h0003_0000, 16'h0100, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'h0001_0000, 16'h0200, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'hFFFE_0000, 16'h0080, 1'b1}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'h0000_0001, 16'hFFFF, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'hFFFF_FFFF, 16'h0001, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'h0000_8000, 16'h0000, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1}},
        '{'{32'h0000_0000, 16'h0100, 1'b1}, 1'b1, '{32'h0000_0000, 1'b0}},
        '{'{32'hFFFF_FFFF, 16'h0001, 1'b0}, 1'b0, '{32'h0000_0000, 1'b0}},
        '{'{32'h0000_0001, 16'h0001, 1'b1}, 1'b0, '{32'h0000_0000, 1'b0}}
    };

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    ivwm_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    ivwm_pkg::t_out o_out_data;

    logic [63:0] acc_num;
    logic [47:0] acc_den;
    logic        acc_err;

    ivwm_pkg::t_out pending_means [$];
    int             n_mismatch = 0;
    bit             steady = 1'b0;    // no idling on either side while set

    inverse_variance_weighted_mean dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_cycles();
        return steady ? 0 : int'($urandom_range(0, 5));
    endfunction

    // folds one pair into the sums; returns 1 with the mean on a last pair
    function automatic bit fold_pair(input ivwm_pkg::t_in b, output ivwm_pkg::t_out r);
        logic [31:0]        sq;
        logic [31:0]        w;
        logic signed [63:0] xs;
        logic [63:0]        prod;
        logic [63:0]        nsum;
        logic [48:0]        nden;
        logic [63:0]        mag;
        logic [63:0]        quo;
        logic               neg;
        r = '0;
        if (b.uncertainty == 16'd0) begin
            acc_err = 1'b1;
        end else begin
            sq = {16'd0, b.uncertainty} * {16'd0, b.uncertainty};
            w = (sq == 32'd1) ? 32'hFFFF_FFFF : 32'(64'h1_0000_0000 / {32'd0, sq});
            xs = {{32{b.measured_value[31]}}, b.measured_value};
            prod = xs * $signed({32'd0, w});
            nsum = acc_num + prod;
            if (acc_num[63] == prod[63] && nsum[63] != prod[63]) begin
                acc_err = 1'b1;
            end
            nden = {1'b0, acc_den} + {17'd0, w};
            if (nden[48]) begin
                acc_err = 1'b1;
            end
            acc_num = nsum;
            acc_den = nden[47:0];
        end
        if (!b.is_last) begin
            return 1'b0;
        end
        if (acc_err || acc_den == 48'd0) begin
            r.weighted_mean = '0;
            r.error_flag = 1'b1;
        end else begin
            neg = acc_num[63];
            mag = neg ? -acc_num : acc_num;
            quo = mag / {16'd0, acc_den};
            if (neg) begin
                if (quo > {32'd0, ivwm_pkg::NEG_LIMIT}) begin
                    quo = {32'd0, ivwm_pkg::NEG_LIMIT};
                end
                r.weighted_mean = -quo[31:0];
            end else begin
                if (quo > {32'd0, ivwm_pkg::POS_LIMIT}) begin
                    quo = {32'd0, ivwm_pkg::POS_LIMIT};
                end
                r.weighted_mean = quo[31:0];
            end
            r.error_flag = 1'b0;
        end
        acc_num = '0;
        acc_den = '0;
        acc_err = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_pair(input ivwm_pkg::t_in b, input logic typed,
                             input ivwm_pkg::t_out typed_res);
        int             gap;
        ivwm_pkg::t_out r;
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (fold_pair(b, r)) begin
            pending_means = {pending_means, (typed ? typed_res : r)};
        end
    endtask

    function automatic ivwm_pkg::t_in random_pair(input logic last);
        ivwm_pkg::t_in b;
        case ($urandom_range(0, 19))
            0:       b.uncertainty = 16'd0;
            1:       b.uncertainty = 16'd1;
            2, 3, 4, 5, 6, 7:
                     b.uncertainty = 16'($urandom_range(1, 255));
            8, 9, 10, 11, 12, 13:
                     b.uncertainty = 16'($urandom_range(256, 4095));
            default: b.uncertainty = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 15))
            0:       b.measured_value = ivwm_pkg::POS_LIMIT;
            1:       b.measured_value = ivwm_pkg::NEG_LIMIT;
            2:       b.measured_value = 32'($urandom_range(0, 255)) << 16;
            default: b.measured_value = $urandom();
        endcase
        b.is_last = last;
        return b;
    endfunction

    // stimulus
    initial begin
        int             sent;
        int             len;
        ivwm_pkg::t_out none;
        none = '0;
        acc_num = '0;
        acc_den = '0;
        acc_err = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_pair(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].res);
        end

        sent = 0;
        while (sent < N_RANDOM) begin
            if ($urandom_range(0, 9) == 0) begin
                steady = !steady;
            end
            len = ($urandom_range(0, 15) == 0) ? 1 : int'($urandom_range(1, 8));
            for (int k = 0; k < len; k++) begin
                send_pair(random_pair(k == len - 1), 1'b0, none);
            end
            sent += len;
        end
        i_in_valid <= 1'b0;

        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        ivwm_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_means.size() == 0) begin
                $error("result beat with no mean expected");
                n_mismatch++;
            end else begin
                want = pending_means.pop_front();
                if (o_out_data.weighted_mean !== want.weighted_mean) begin
                    $error("weighted_mean: expected %h, got %h",
                           want.weighted_mean, o_out_data.weighted_mean);
                    n_mismatch++;
                end
                if (o_out_data.error_flag !== want.error_flag) begin
                    $error("error_flag: expected %b, got %b",
                           want.error_flag, o_out_data.error_flag);
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### inverse_variance_weighted_mean.f
rtl/core/ivwm_pkg.sv
rtl/core/inverse_variance_weighted_mean.sv
tb/inverse_variance_weighted_mean_tb.sv
